// ===== design/prq_pkg.sv =====
package prq_pkg;

  // Default sizing of the queue
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PRIO_BITS_DEF   = 8;
  localparam int ID_BITS         = 4;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } prq_ctl_t;

endpackage

// ===== design/prq_cell.sv =====
module prq_cell #(
  parameter int PRIO_BITS = prq_pkg::PRIO_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  prq_pkg::prq_ctl_t         ctl,
  input  logic [prq_pkg::ID_BITS-1:0] new_id,
  input  logic [PRIO_BITS-1:0]      new_prio,
  input  logic                      left_ge,
  input  logic                      left_valid,
  input  logic [prq_pkg::ID_BITS-1:0] left_id,
  input  logic [PRIO_BITS-1:0]      left_prio,
  input  logic                      right_valid,
  input  logic [prq_pkg::ID_BITS-1:0] right_id,
  input  logic [PRIO_BITS-1:0]      right_prio,
  output logic                      ge,
  output logic                      valid,
  output logic [prq_pkg::ID_BITS-1:0] id,
  output logic [PRIO_BITS-1:0]      prio
);
  import prq_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  // Keep this entry ahead of the new one when its priority is greater or equal
  assign ge = valid_r && (prio_r >= new_prio);

  // Hold, insert the new entry, shift from the left on insert or from the right on removal
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    if (ctl.enq && !ge) begin
      if (left_ge) begin
        valid_nxt = 1'b1;
        id_nxt    = new_id;
        prio_nxt  = new_prio;
      end else begin
        valid_nxt = left_valid;
        id_nxt    = left_id;
        prio_nxt  = left_prio;
      end
    end else if (ctl.deq) begin
      valid_nxt = right_valid;
      id_nxt    = right_id;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;
  assign prio  = prio_r;

endmodule

// ===== design/priority_ready_queue.sv =====
// Stable priority queue of process ids held in a row of compare-and-shift cells, highest
// priority at the head, equal priorities in arrival order. One command is taken per clock:
// busy stays low, so a command may be given on every cycle. Each command yields one result,
// strobed by out_valid for a single cycle on the clock after the command transfer; the
// receiver cannot stall it and must take it then. All cells compare the new priority in
// parallel and insert or shift in the same edge. An enqueue into a full queue is refused
// with the full status; a dequeue from an empty queue returns the empty status. out_held
// reports the count after the command.
module priority_ready_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIO_BITS   = prq_pkg::PRIO_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [prq_pkg::ID_BITS-1:0]         in_proc_id,
  input  logic [PRIO_BITS-1:0]                in_prio,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [prq_pkg::ID_BITS-1:0]         out_id,
  output logic [PRIO_BITS-1:0]                out_prio,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_held
);
  import prq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                 accept;
  logic                 full, empty;
  prq_ctl_t             ctl;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [ID_BITS-1:0]   out_id_r, out_id_nxt;
  logic [PRIO_BITS-1:0] out_prio_r, out_prio_nxt;
  logic [CNT_W-1:0]     out_held_r;

  logic [QUEUE_DEPTH-1:0] valid_w;
  logic [QUEUE_DEPTH-1:0] ge_w;
  logic [ID_BITS-1:0]     id_w   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0]   prio_w [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  // Decode the command, drop it on the guarded cases
  always_comb begin
    ctl.enq = accept && (in_cmd == CMD_ENQ) && !full;
    ctl.deq = accept && (in_cmd == CMD_DEQ) && !empty;
  end

  // Build the chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_ge, l_valid, r_valid;
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_ge    = 1'b1;
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_prio  = '0;
    end else begin : g_body
      assign l_ge    = ge_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_id    = id_w[i-1];
      assign l_prio  = prio_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = valid_w[i+1];
      assign r_id    = id_w[i+1];
      assign r_prio  = prio_w[i+1];
    end

    prq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_id     (in_proc_id),
      .new_prio   (in_prio),
      .left_ge    (l_ge),
      .left_valid (l_valid),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_valid(r_valid),
      .right_id   (r_id),
      .right_prio (r_prio),
      .ge         (ge_w[i]),
      .valid      (valid_w[i]),
      .id         (id_w[i]),
      .prio       (prio_w[i])
    );
  end

  // Advance the count and form the result
  always_comb begin
    count_nxt      = count_r;
    out_status_nxt = ST_DONE;
    out_id_nxt     = '0;
    out_prio_nxt   = '0;
    if (ctl.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.deq) begin
      count_nxt    = count_r - 1'b1;
      out_id_nxt   = id_w[0];
      out_prio_nxt = prio_w[0];
    end
    if (in_cmd == CMD_ENQ && full) begin
      out_status_nxt = ST_FULL;
    end else if (in_cmd == CMD_DEQ && empty) begin
      out_status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Capture the result payload on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_prio_r   <= out_prio_nxt;
      out_held_r   <= count_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_prio   = out_prio_r;
  assign out_held   = out_held_r;

  // Occupied cells match the count
  a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(count_r))
    else $error("occupied cells disagree with count");

  // The head cell is occupied exactly when the queue is not empty
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[0] == !empty)
    else $error("head cell occupancy wrong");

  // Count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("count beyond depth");

  // Every transfer gives a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result strobe");

  // A successful dequeue reports the old head
  a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.deq |=> (out_id == $past(id_w[0])) && (out_prio == $past(prio_w[0])))
    else $error("dequeue returned wrong entry");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import prq_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int PBITS      = PRIO_BITS_DEF;
  localparam int HELD_BITS  = $clog2(DEPTH + 1);
  localparam int ITEM_COUNT = 1950;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic               cmd;
    logic [ID_BITS-1:0] pid;
    logic [PBITS-1:0]   prio;
  } sched_cmd_t;

  typedef struct {
    logic [1:0]           status;
    logic [ID_BITS-1:0]   pid;
    logic [PBITS-1:0]     prio;
    logic [HELD_BITS-1:0] held;
  } sched_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_cmd = CMD_ENQ;
  logic [ID_BITS-1:0]   in_proc_id = '0;
  logic [PBITS-1:0]     in_prio = '0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [ID_BITS-1:0]   out_id;
  logic [PBITS-1:0]     out_prio;
  logic [HELD_BITS-1:0] out_held;

  // Mirror of the ready queue, head at index 0
  logic [ID_BITS-1:0]   mirror_ids   [DEPTH];
  logic [PBITS-1:0]     mirror_prios [DEPTH];
  int                   mirror_count;

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  sched_result_t head_result;
  int            total_cmds;
  int            issued_count;
  int            accepted_count;
  int            error_count;
  int            cycle_count;

  priority_ready_queue #(
    .QUEUE_DEPTH(DEPTH),
    .PRIO_BITS  (PBITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_proc_id(in_proc_id),
    .in_prio   (in_prio),
    .out_valid (out_valid),
    .out_status(out_status),
    .out_id    (out_id),
    .out_prio  (out_prio),
    .out_held  (out_held)
  );

  // Apply one command to the mirror and queue the result it yields
  task predict_sched_step(input logic cmd, input logic [ID_BITS-1:0] pid,
                          input logic [PBITS-1:0] prio);
    sched_result_t res;
    int pos;
    int k;
    res.status = ST_DONE;
    res.pid    = '0;
    res.prio   = '0;
    if (cmd == CMD_ENQ) begin
      if (mirror_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // insert behind every entry of greater or equal priority
        pos = 0;
        while (pos < mirror_count && mirror_prios[pos] >= prio) pos++;
        for (k = mirror_count; k > pos; k--) begin
          mirror_ids[k]   = mirror_ids[k-1];
          mirror_prios[k] = mirror_prios[k-1];
        end
        mirror_ids[pos]   = pid;
        mirror_prios[pos] = prio;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.pid  = mirror_ids[0];
        res.prio = mirror_prios[0];
        for (k = 0; k + 1 < mirror_count; k++) begin
          mirror_ids[k]   = mirror_ids[k+1];
          mirror_prios[k] = mirror_prios[k+1];
        end
        mirror_count--;
        mirror_ids[mirror_count]   = '0;
        mirror_prios[mirror_count] = '0;
      end
    end
    res.held = HELD_BITS'(mirror_count);
    expected_results.push_back(res);
  endtask

  task add_cmd(input logic cmd, input int pid, input int prio);
    sched_cmd_t c;
    c.cmd  = cmd;
    c.pid  = ID_BITS'(pid);
    c.prio = PBITS'(prio);
    pending_cmds.push_back(c);
  endtask

  // Sender idle rate per phase: 23, then 56, then none
  function automatic bit sender_idles();
    int pct;
    if (issued_count < ITEM_COUNT / 3) pct = 23;
    else if (issued_count < 2 * ITEM_COUNT / 3) pct = 56;
    else pct = 0;
    return $urandom_range(99) < pct;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  // Build the stimulus, release reset, wait for the drain
  initial begin
    int burst_len;
    int enq_pct;
    int prio;
    int i;
    for (i = 0; i < DEPTH; i++) begin
      mirror_ids[i]   = '0;
      mirror_prios[i] = '0;
    end
    mirror_count   = 0;
    issued_count   = 0;
    accepted_count = 0;
    error_count    = 0;

    // directed: empty dequeue, field extremes, ties, fill past full, drain a few
    add_cmd(CMD_DEQ, 15, 255);
    add_cmd(CMD_ENQ, 0, 0);
    add_cmd(CMD_ENQ, 15, 255);
    add_cmd(CMD_ENQ, 5, 255);
    add_cmd(CMD_ENQ, 10, 0);
    add_cmd(CMD_ENQ, 3, 128);
    add_cmd(CMD_ENQ, 12, 127);
    add_cmd(CMD_ENQ, 1, 128);
    for (i = 0; i < 9; i++) add_cmd(CMD_ENQ, i + 6, (i * 37) % 256);
    add_cmd(CMD_ENQ, 9, 200);
    add_cmd(CMD_ENQ, 7, 255);
    add_cmd(CMD_DEQ, 0, 0);
    add_cmd(CMD_DEQ, 0, 0);
    add_cmd(CMD_DEQ, 0, 0);
    add_cmd(CMD_DEQ, 0, 0);

    // random bursts that swing the queue between empty and full
    while (pending_cmds.size() < ITEM_COUNT) begin
      burst_len = $urandom_range(4, 40);
      case ($urandom_range(2))
        0: enq_pct = 80;
        1: enq_pct = 20;
        default: enq_pct = 50;
      endcase
      for (i = 0; i < burst_len; i++) begin
        case ($urandom_range(2))
          0: prio = $urandom_range(255);
          1: prio = $urandom_range(3);
          default: prio = 255 - $urandom_range(3);
        endcase
        add_cmd(($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                $urandom_range(15), prio);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge to stay clear of the driver's updates
    while (accepted_count < total_cmds || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Driver: predict on each transfer, then present the next command or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_cmd     <= CMD_ENQ;
      in_proc_id <= '0;
      in_prio    <= '0;
    end else begin
      if (start && !busy) begin
        predict_sched_step(in_cmd, in_proc_id, in_prio);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && !sender_idles()) begin
          in_cmd     <= pending_cmds[0].cmd;
          in_proc_id <= pending_cmds[0].pid;
          in_prio    <= pending_cmds[0].prio;
          start      <= 1'b1;
          void'(pending_cmds.pop_front());
          issued_count++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d id %0d prio %0d held %0d",
               out_status, out_id, out_prio, out_held);
        error_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (out_status !== head_result.status) begin
          $error("out_status expected %0d actual %0d", head_result.status, out_status);
          error_count++;
        end
        if (out_id !== head_result.pid) begin
          $error("out_id expected %0d actual %0d", head_result.pid, out_id);
          error_count++;
        end
        if (out_prio !== head_result.prio) begin
          $error("out_prio expected %0d actual %0d", head_result.prio, out_prio);
          error_count++;
        end
        if (out_held !== head_result.held) begin
          $error("out_held expected %0d actual %0d", head_result.held, out_held);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
